FILE: src/tcc3d_pkg.sv
// -----------------------------------------------------------------------------
// tcc3d_pkg - shared widths and stage types
// Field widths, datapath widths and the per-stage payload structs of the
// triangle circumcenter pipeline.
// -----------------------------------------------------------------------------
package tcc3d_pkg;

   localparam int COORD_BITS = 16;               // input coordinate width
   localparam int FRAC_BITS  = 8;                // fraction bits, in and out alike
   localparam int OUTW       = 24;               // output coordinate width
   localparam int DIFW       = COORD_BITS + 1;   // vertex difference
   localparam int SQW        = 2 * COORD_BITS + 1;   // one squared difference
   localparam int TW         = SQW + 1;          // squared edge length
   localparam int EW         = TW + 2;           // t_b + t_c - t_a
   localparam int TSPLIT     = (TW + 1) / 2;     // low slice of t for the multiply
   localparam int PPW        = 54;               // partial product width
   localparam int WW         = 72;               // weight
   localparam int WSPLIT     = WW / 2;           // low slice of a weight
   localparam int TOTW       = WW + 2;           // total weight
   localparam int NW         = 90;               // weighted numerator
   localparam int NAW        = NW - 1;           // numerator magnitude
   localparam int DAW        = TOTW - 1;         // total weight magnitude
   localparam int RW         = NW + 1;           // 2n + d
   localparam int DW         = DAW + 2;          // 2d
   localparam int QB         = 26;               // quotient bits kept
   localparam int CMPW       = DW + QB;          // divider compare width
   localparam int SUMW       = QB + 2;           // c + q before clipping
   localparam int NS         = 12 + QB;          // pipeline stages incl. output
   localparam int S_OUT      = NS - 1;

   localparam logic signed [OUTW-1:0] CLIP_HI = {1'b0, {(OUTW-1){1'b1}}};
   localparam logic signed [OUTW-1:0] CLIP_LO = {1'b1, {(OUTW-1){1'b0}}};

   typedef logic [2:0][DIFW-1:0]       diff3_type;
   typedef logic [2:0][COORD_BITS-1:0] coord3_type;

   typedef struct packed {
      diff3_type  dab;
      diff3_type  dac;
      diff3_type  dbc;
      coord3_type c;
   } s1_type;

   typedef struct packed {
      logic [2:0][SQW-1:0] sab;
      logic [2:0][SQW-1:0] sac;
      logic [2:0][SQW-1:0] sbc;
      diff3_type  dac;
      diff3_type  dbc;
      coord3_type c;
   } s2_type;

   typedef struct packed {
      logic [2:0][TW-1:0] t;
      diff3_type  dac;
      diff3_type  dbc;
      coord3_type c;
   } s3_type;

   typedef struct packed {
      logic [2:0][TW-1:0] t;
      logic [2:0][EW-1:0] e;
      diff3_type  dac;
      diff3_type  dbc;
      coord3_type c;
   } s4_type;

   typedef struct packed {
      logic [2:0][PPW-1:0] pl;
      logic [2:0][PPW-1:0] ph;
      diff3_type  dac;
      diff3_type  dbc;
      coord3_type c;
   } s5_type;

   typedef struct packed {
      logic [2:0][WW-1:0] w;
      diff3_type  dac;
      diff3_type  dbc;
      coord3_type c;
   } s6_type;

   typedef struct packed {
      logic [TOTW-1:0]     tot;
      logic [2:0][PPW-1:0] al;
      logic [2:0][PPW-1:0] ah;
      logic [2:0][PPW-1:0] bl;
      logic [2:0][PPW-1:0] bh;
      coord3_type c;
   } s7_type;

   typedef struct packed {
      logic [TOTW-1:0]    tot;
      logic [2:0][NW-1:0] num;
      coord3_type c;
   } s8_type;

   typedef struct packed {
      logic [2:0][NAW-1:0] nab;
      logic [DAW-1:0]      tabs;
      logic [2:0]          neg;
      logic                degen;
      coord3_type c;
   } s9_type;

   typedef struct packed {
      logic [2:0][RW-1:0] rem;
      logic [DW-1:0]      dd;
      logic [2:0]         neg;
      logic               degen;
      coord3_type c;
   } s10_type;

   typedef struct packed {
      logic [2:0][RW-1:0] rem;
      logic [2:0][QB-1:0] q;
      logic [DW-1:0]      dd;
      logic [2:0]         neg;
      logic [2:0]         ovf;
      logic               degen;
      coord3_type c;
   } div_type;

   typedef struct packed {
      logic [2:0][OUTW-1:0] center;
      logic                 degen;
      logic                 sat;
   } out_type;

endpackage

FILE: src/triangle_circumcenter_3d.sv
// -----------------------------------------------------------------------------
// triangle_circumcenter_3d - pipelined 3D triangle circumcenter
// Squared edge lengths, barycentric weights, weighted numerators and a
// one-bit-per-stage restoring divider, rounded and clipped to Q16.8.
// -----------------------------------------------------------------------------
//
//  channel  dir  beat contents (low bits first)
//  -------  ---  -----------------------------------------------------------
//  req_     in   tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z, 16 bits each
//  rsp_     out  tdata: center_x center_y center_z, 24 bits each
//                tuser: degenerate, saturated
//
//  One beat enters per cycle while the skid register is empty; a taken
//  beat passes ten arithmetic stages, the divider head, 26 quotient stages
//  and the output register.
//  Reset (synchronous) empties every stage and the skid register.
//  A stall on rsp_tready parks the finished beat in the skid register while
//  the pipeline still advances in that cycle; the pipeline freezes only while that
//  register is full, so no beat is lost or repeated.
//
module triangle_circumcenter_3d
   import tcc3d_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [9*COORD_BITS-1:0]   req_tdata,   // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3*OUTW-1:0]         rsp_tdata,   // center_x, center_y, center_z
   output logic [1:0]                rsp_tuser    // degenerate, saturated
);

   // Stage valid bits travel with the payload; the whole pipe steps on adv.
   logic [NS-1:0] v_ff, v_in;
   logic          adv;
   logic          sk_v_ff, sk_v_in;
   out_type       sk_ff, sk_in;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   s7_type  s7_ff, s7_in;
   s8_type  s8_ff, s8_in;
   s9_type  s9_ff, s9_in;
   s10_type s10_ff, s10_in;
   div_type dv_ff [QB+1];
   div_type dv_in [QB+1];
   out_type out_ff, out_in;

   // Advance whenever the skid register is free.
   assign adv        = !sk_v_ff;
   assign req_tready = adv;

   assign v_in = {v_ff[NS-2:0], req_tvalid};

   // Stage 1: vertex differences; keep C for the final add.
   always_comb begin
      logic signed [DIFW-1:0] ax, bx, cx;
      for (int i = 0; i < 3; i++) begin
         ax = DIFW'($signed(req_tdata[COORD_BITS*i +: COORD_BITS]));
         bx = DIFW'($signed(req_tdata[COORD_BITS*(3+i) +: COORD_BITS]));
         cx = DIFW'($signed(req_tdata[COORD_BITS*(6+i) +: COORD_BITS]));
         s1_in.dab[i] = ax - bx;
         s1_in.dac[i] = ax - cx;
         s1_in.dbc[i] = bx - cx;
         s1_in.c[i]   = req_tdata[COORD_BITS*(6+i) +: COORD_BITS];
      end
   end

   // Stage 2: squared differences.
   always_comb begin
      logic signed [2*DIFW-1:0] pab, pac, pbc;
      for (int i = 0; i < 3; i++) begin
         pab = $signed(s1_ff.dab[i]) * $signed(s1_ff.dab[i]);
         pac = $signed(s1_ff.dac[i]) * $signed(s1_ff.dac[i]);
         pbc = $signed(s1_ff.dbc[i]) * $signed(s1_ff.dbc[i]);
         s2_in.sab[i] = pab[SQW-1:0];
         s2_in.sac[i] = pac[SQW-1:0];
         s2_in.sbc[i] = pbc[SQW-1:0];
      end
      s2_in.dac = s1_ff.dac;
      s2_in.dbc = s1_ff.dbc;
      s2_in.c   = s1_ff.c;
   end

   // Stage 3: squared edge lengths t_a = |B-C|^2, t_b = |A-C|^2, t_c = |A-B|^2.
   always_comb begin
      s3_in.t[0] = TW'(s2_ff.sbc[0]) + TW'(s2_ff.sbc[1]) + TW'(s2_ff.sbc[2]);
      s3_in.t[1] = TW'(s2_ff.sac[0]) + TW'(s2_ff.sac[1]) + TW'(s2_ff.sac[2]);
      s3_in.t[2] = TW'(s2_ff.sab[0]) + TW'(s2_ff.sab[1]) + TW'(s2_ff.sab[2]);
      s3_in.dac  = s2_ff.dac;
      s3_in.dbc  = s2_ff.dbc;
      s3_in.c    = s2_ff.c;
   end

   // Stage 4: weight factors e_k = sum of the other two minus t_k.
   always_comb begin
      logic [EW-1:0] ta, tb, tc;
      ta = EW'(s3_ff.t[0]);
      tb = EW'(s3_ff.t[1]);
      tc = EW'(s3_ff.t[2]);
      s4_in.t    = s3_ff.t;
      s4_in.e[0] = tb + tc - ta;
      s4_in.e[1] = tc + ta - tb;
      s4_in.e[2] = ta + tb - tc;
      s4_in.dac  = s3_ff.dac;
      s4_in.dbc  = s3_ff.dbc;
      s4_in.c    = s3_ff.c;
   end

   // Stage 5: t * e as two half-width partial products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_in.pl[i] = PPW'($signed({1'b0, s4_ff.t[i][TSPLIT-1:0]}) * $signed(s4_ff.e[i]));
         s5_in.ph[i] = PPW'($signed({1'b0, s4_ff.t[i][TW-1:TSPLIT]}) * $signed(s4_ff.e[i]));
      end
      s5_in.dac = s4_ff.dac;
      s5_in.dbc = s4_ff.dbc;
      s5_in.c   = s4_ff.c;
   end

   // Stage 6: merge the partials into the weights.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_in.w[i] = (WW'($signed(s5_ff.ph[i])) <<< TSPLIT) + WW'($signed(s5_ff.pl[i]));
      end
      s6_in.dac = s5_ff.dac;
      s6_in.dbc = s5_ff.dbc;
      s6_in.c   = s5_ff.c;
   end

   // Stage 7: total weight, and w_a*(A-C), w_b*(B-C) as split partials.
   always_comb begin
      s7_in.tot = TOTW'($signed(s6_ff.w[0])) + TOTW'($signed(s6_ff.w[1]))
                + TOTW'($signed(s6_ff.w[2]));
      for (int i = 0; i < 3; i++) begin
         s7_in.al[i] = PPW'($signed({1'b0, s6_ff.w[0][WSPLIT-1:0]}) * $signed(s6_ff.dac[i]));
         s7_in.ah[i] = PPW'($signed(s6_ff.w[0][WW-1:WSPLIT]) * $signed(s6_ff.dac[i]));
         s7_in.bl[i] = PPW'($signed({1'b0, s6_ff.w[1][WSPLIT-1:0]}) * $signed(s6_ff.dbc[i]));
         s7_in.bh[i] = PPW'($signed(s6_ff.w[1][WW-1:WSPLIT]) * $signed(s6_ff.dbc[i]));
      end
      s7_in.c = s6_ff.c;
   end

   // Stage 8: numerators.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s8_in.num[i] = (NW'($signed(s7_ff.ah[i])) <<< WSPLIT) + NW'($signed(s7_ff.al[i]))
                      + (NW'($signed(s7_ff.bh[i])) <<< WSPLIT) + NW'($signed(s7_ff.bl[i]));
      end
      s8_in.tot = s7_ff.tot;
      s8_in.c   = s7_ff.c;
   end

   // Stage 9: magnitudes and quotient sign.
   always_comb begin
      logic [NW-1:0]   nneg;
      logic [TOTW-1:0] tneg;
      tneg = -s8_ff.tot;
      s9_in.tabs  = s8_ff.tot[TOTW-1] ? tneg[DAW-1:0] : s8_ff.tot[DAW-1:0];
      s9_in.degen = (s8_ff.tot == '0);
      for (int i = 0; i < 3; i++) begin
         nneg = -s8_ff.num[i];
         s9_in.nab[i] = s8_ff.num[i][NW-1] ? nneg[NAW-1:0] : s8_ff.num[i][NAW-1:0];
         s9_in.neg[i] = s8_ff.num[i][NW-1] ^ s8_ff.tot[TOTW-1];
      end
      s9_in.c = s8_ff.c;
   end

   // Stage 10: round half away from zero as floor((2n + d) / 2d).
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s10_in.rem[i] = {1'b0, s9_ff.nab[i], 1'b0} + RW'(s9_ff.tabs);
      end
      s10_in.dd    = {1'b0, s9_ff.tabs, 1'b0};
      s10_in.neg   = s9_ff.neg;
      s10_in.degen = s9_ff.degen;
      s10_in.c     = s9_ff.c;
   end

   // Divider head: flag quotients too large for the kept bits.
   always_comb begin
      logic [CMPW-1:0] lim;
      lim = CMPW'(s10_ff.dd) << QB;
      dv_in[0].rem   = s10_ff.rem;
      dv_in[0].q     = '0;
      dv_in[0].dd    = s10_ff.dd;
      dv_in[0].neg   = s10_ff.neg;
      dv_in[0].degen = s10_ff.degen;
      dv_in[0].c     = s10_ff.c;
      for (int i = 0; i < 3; i++) begin
         dv_in[0].ovf[i] = (CMPW'(s10_ff.rem[i]) >= lim);
      end
   end

   // Restoring divider, one quotient bit per stage, MSB first.
   for (genvar j = 0; j < QB; j++) begin : g_div
      localparam int K = QB - 1 - j;
      always_comb begin
         logic [CMPW-1:0] sh, r;
         dv_in[j+1] = dv_ff[j];
         sh = CMPW'(dv_ff[j].dd) << K;
         for (int i = 0; i < 3; i++) begin
            r = CMPW'(dv_ff[j].rem[i]);
            if (r >= sh) begin
               r = r - sh;
               dv_in[j+1].q[i][K] = 1'b1;
            end
            dv_in[j+1].rem[i] = r[RW-1:0];
         end
      end
   end

   // Output stage: apply sign, add C, clip; a degenerate beat gives a zero center.
   always_comb begin
      logic signed [SUMW-1:0] sq, sum;
      logic [2:0]             clip;
      div_type                d;
      d = dv_ff[QB];
      for (int i = 0; i < 3; i++) begin
         sq  = d.neg[i] ? -$signed(SUMW'(d.q[i])) : $signed(SUMW'(d.q[i]));
         sum = SUMW'($signed(d.c[i])) + sq;
         clip[i] = 1'b1;
         if (d.ovf[i]) begin
            out_in.center[i] = d.neg[i] ? CLIP_LO : CLIP_HI;
         end else if (sum < SUMW'(CLIP_LO)) begin
            out_in.center[i] = CLIP_LO;
         end else if (sum > SUMW'(CLIP_HI)) begin
            out_in.center[i] = CLIP_HI;
         end else begin
            out_in.center[i] = sum[OUTW-1:0];
            clip[i] = 1'b0;
         end
      end
      out_in.degen = d.degen;
      out_in.sat   = |clip;
      if (d.degen) begin
         out_in.center = '0;
         out_in.sat    = 1'b0;
      end
   end

   // Skid: catch the output beat when it is not taken while the pipe steps.
   always_comb begin
      sk_v_in = sk_v_ff;
      sk_in   = sk_ff;
      if (sk_v_ff) begin
         if (rsp_tready) sk_v_in = 1'b0;
      end else if (v_ff[S_OUT] && !rsp_tready) begin
         sk_v_in = 1'b1;
         sk_in   = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         sk_v_ff <= 1'b0;
      end else begin
         if (adv) v_ff <= v_in;
         sk_v_ff <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      sk_ff <= sk_in;
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         for (int j = 0; j <= QB; j++) dv_ff[j] <= dv_in[j];
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = sk_v_ff | v_ff[S_OUT];
   assign rsp_tdata  = sk_v_ff ? sk_ff.center : out_ff.center;
   assign rsp_tuser  = sk_v_ff ? {sk_ff.sat, sk_ff.degen} : {out_ff.sat, out_ff.degen};

endmodule

FILE: src/tcc3d_checker.sv
// -----------------------------------------------------------------------------
// tcc3d_checker - port-level checks for the circumcenter block
// Watches the result channel for handshake and result consistency.
// -----------------------------------------------------------------------------
module tcc3d_checker
   import tcc3d_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [3*OUTW-1:0] rsp_tdata,
   input logic [1:0]        rsp_tuser
);

   function automatic logic at_bound(input logic [OUTW-1:0] v);
      return (v == CLIP_HI) || (v == CLIP_LO);
   endfunction

   // Hold a stalled beat.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Drop all results out of reset.
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Degenerate beats carry a zero center and no clip flag.
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("degenerate beat with nonzero center");

   // A clipped beat shows at least one coordinate at a range bound.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         at_bound(rsp_tdata[OUTW-1:0]) || at_bound(rsp_tdata[2*OUTW-1:OUTW])
         || at_bound(rsp_tdata[3*OUTW-1:2*OUTW]))
      else $error("saturated beat without a clipped coordinate");

endmodule

bind triangle_circumcenter_3d tcc3d_checker u_tcc3d_checker (.*);

FILE: bench/triangle_circumcenter_3d_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// triangle_circumcenter_3d_tb - self-checking bench for the circumcenter pipe
// Streams triangles into the block, computes each expected circumcenter with
// wide integer arithmetic and compares every result beat field by field, with
// random idle bursts on both sides of the stream.
// -----------------------------------------------------------------------------
module triangle_circumcenter_3d_tb
   import tcc3d_pkg::*;
;

   typedef logic signed [191:0]          wide_type;
   typedef logic [8:0][COORD_BITS-1:0]   tri_type;

   typedef struct packed {
      logic [OUTW-1:0] cx;
      logic [OUTW-1:0] cy;
      logic [OUTW-1:0] cz;
      logic            degen;
      logic            sat;
   } center_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;     // idle wait after the last result

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [9*COORD_BITS-1:0] req_tdata = '0;   // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [3*OUTW-1:0]       rsp_tdata;        // center_x, center_y, center_z
   logic [1:0]              rsp_tuser;        // degenerate, saturated

   center_type pending_centers[$];
   int      n_sent = 0, n_checked = 0, n_degen = 0, n_sat = 0, n_errors = 0;
   int      cycles = 0, stall_left = 0;
   bit      quiet = 1'b0;       // no idling in the closing stretch

   triangle_circumcenter_3d DUT (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Exact circumcenter: C + (wA*(A-C) + wB*(B-C)) / S, rounded half away
   // from zero, then clipped to the 24-bit output range.
   function automatic center_type circumcenter(tri_type t);
      wide_type   a[3], b[3], c[3];
      wide_type   ta, tb, tc, wa, wb, wc, tot, num, n, d, q, v;
      wide_type   lo, hi;
      center_type r;
      logic [OUTW-1:0] o[3];
      lo = -(wide_type'(1) <<< (OUTW - 1));
      hi = (wide_type'(1) <<< (OUTW - 1)) - 1;
      for (int i = 0; i < 3; i++) begin
         a[i] = $signed(t[i]);
         b[i] = $signed(t[3 + i]);
         c[i] = $signed(t[6 + i]);
      end
      ta = 0; tb = 0; tc = 0;
      for (int i = 0; i < 3; i++) begin
         ta += (b[i] - c[i]) * (b[i] - c[i]);
         tb += (a[i] - c[i]) * (a[i] - c[i]);
         tc += (a[i] - b[i]) * (a[i] - b[i]);
      end
      wa = ta * (tb + tc - ta);
      wb = tb * (tc + ta - tb);
      wc = tc * (ta + tb - tc);
      tot = wa + wb + wc;
      r = '0;
      if (tot == 0) begin
         r.degen = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         num = wa * (a[i] - c[i]) + wb * (b[i] - c[i]);
         n = (num < 0) ? -num : num;
         d = (tot < 0) ? -tot : tot;
         q = (2 * n + d) / (2 * d);
         if ((num < 0) != (tot < 0)) q = -q;
         v = c[i] + q;
         if (v < lo) begin
            v = lo;
            r.sat = 1'b1;
         end else if (v > hi) begin
            v = hi;
            r.sat = 1'b1;
         end
         o[i] = v[OUTW-1:0];
      end
      r.cx = o[0]; r.cy = o[1]; r.cz = o[2];
      return r;
   endfunction

   // Drive one triangle, sometimes after a random idle gap, and hold it until the beat is taken.
   task automatic send_triangle(tri_type t);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      pending_centers.push_back(circumcenter(t));
      n_sent++;
   endtask

   function automatic tri_type make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz);
      tri_type t;
      t[0] = COORD_BITS'(ax); t[1] = COORD_BITS'(ay); t[2] = COORD_BITS'(az);
      t[3] = COORD_BITS'(bx); t[4] = COORD_BITS'(by); t[5] = COORD_BITS'(bz);
      t[6] = COORD_BITS'(cx); t[7] = COORD_BITS'(cy); t[8] = COORD_BITS'(cz);
      return t;
   endfunction

   // Zero, coincident and collinear vertices: total weight vanishes.
   task automatic test_degenerate();
      send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_triangle(make_tri(300, -40, 7, 300, -40, 7, 300, -40, 7));
      send_triangle(make_tri(-32768, 0, 0, 0, 0, 0, 32767, 0, 0));
      send_triangle(make_tri(100, 200, 300, 200, 400, 600, 300, 600, 900));
      send_triangle(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                             32767, 32767, 32767));
      send_triangle(make_tri(5, 5, 5, 9, 1, -3, 5, 5, 5));
   endtask

   // Corners of the coordinate range and ordinary shapes.
   task automatic test_extremes();
      send_triangle(make_tri(32767, 32767, 32767, -32768, -32768, 32767,
                             -32768, 32767, -32768));
      send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                             32767, -32768, 32767));
      send_triangle(make_tri(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
      send_triangle(make_tri(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
      send_triangle(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));         // right angle
      send_triangle(make_tri(256, 0, 0, 0, 256, 0, 0, 0, 256));       // equilateral
      send_triangle(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 0));             // rounding tie
      send_triangle(make_tri(-1, 0, 0, 0, -1, 0, 0, 0, 0));
      send_triangle(make_tri(32767, -32768, 1, -1, 0, -32768, 12345, -4321, 32767));
   endtask

   // Very flat triangles push the center far outside the output range.
   task automatic test_saturation();
      send_triangle(make_tri(-32768, 0, 0, 32767, 0, 0, 0, 1, 0));
      send_triangle(make_tri(-32768, 0, 0, 32767, 0, 0, 0, -1, 0));
      send_triangle(make_tri(0, -32768, 0, 0, 32767, 0, 1, 0, 0));
      send_triangle(make_tri(0, 0, -32768, 0, 0, 32767, 0, 0, 1));
      send_triangle(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                             0, 0, 1));
      send_triangle(make_tri(32767, 32767, 0, -32768, -32768, 0, 1, 0, 0));
   endtask

   // Mostly full-range triangles, with small, flat and degenerate ones mixed in.
   task automatic test_random(int count);
      tri_type t;
      int   k, pick;
      int   ai, bi, ni;
      for (int n = 0; n < count; n++) begin
         if (n == count - 100) quiet = 1'b1;
         pick = $urandom_range(0, 9);
         for (int i = 0; i < 9; i++) t[i] = COORD_BITS'($urandom);
         if (pick < 2) begin
            for (int i = 0; i < 9; i++)
               t[i] = COORD_BITS'(int'($urandom_range(0, 1023)) - 512);
         end else if (pick < 4) begin
            // C lies near the line AB
            k = int'($urandom_range(0, 4)) - 2;
            for (int i = 0; i < 3; i++) begin
               ai = $signed(t[i]);
               bi = $signed(t[3 + i]);
               ni = int'($urandom_range(0, 6)) - 3;
               t[6 + i] = COORD_BITS'(ai + k * (bi - ai) / 4 + ni);
            end
         end else if (pick == 4) begin
            k = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) t[3 * ((k + 1) % 3) + i] = t[3 * k + i];
         end
         send_triangle(t);
      end
      req_tvalid <= 1'b0;
   endtask

   // Result side: check each beat, then pick the next ready value.
   always @(posedge clock) begin
      center_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[OUTW-1:0], rsp_tdata[2*OUTW-1:OUTW],
                rsp_tdata[3*OUTW-1:2*OUTW], rsp_tuser[0], rsp_tuser[1]};
         if (pending_centers.size() == 0) begin
            $error("result beat with no triangle outstanding");
            n_errors++;
         end else begin
            want = pending_centers.pop_front();
            n_checked++;
            n_degen += want.degen;
            n_sat   += want.sat;
            if (got.cx !== want.cx) begin
               $error("center_x expected %h actual %h", want.cx, got.cx);
               n_errors++;
            end
            if (got.cy !== want.cy) begin
               $error("center_y expected %h actual %h", want.cy, got.cy);
               n_errors++;
            end
            if (got.cz !== want.cz) begin
               $error("center_z expected %h actual %h", want.cz, got.cz);
               n_errors++;
            end
            if (got.degen !== want.degen) begin
               $error("degenerate expected %b actual %b", want.degen, got.degen);
               n_errors++;
            end
            if (got.sat !== want.sat) begin
               $error("saturated expected %b actual %b", want.sat, got.sat);
               n_errors++;
            end
         end
      end
      // stall in bursts, never in the closing stretch
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_degenerate();
      test_extremes();
      test_saturation();
      test_random(830);
      // drain: wait for every result, then a little past the latency
      while (pending_centers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_centers.size() != 0) n_errors++;
      $display("covered %0d triangles, %0d results checked", n_sent, n_checked);
      $display("of them %0d degenerate and %0d clipped", n_degen, n_sat);
      if (n_errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
